FILE: rtl/core/ssvt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssvt_pkg: shared definitions of the sweeping sector visibility test
// Widths, fixed-point constants, register indexes, operation codes, the
// sequencer state type and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ssvt_pkg;

  // Number of CORDIC vectoring iterations; the table holds 24 entries.
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int ITER_W = $clog2(CORDIC_ITERS);

  // Angle units: 1/16 degree, with 16 fraction bits in the bearing path.
  localparam int FULL_TURN  = 5760;
  localparam int HALF_TURN  = 2880;
  localparam int FRAC_SHIFT = 16;
  localparam int PRE_SHIFT  = 24;

  // Widths of the internal datapath.
  localparam int ANG_W = 13;  // view angle and angle registers
  localparam int D_W   = 19;  // doubled offsets from the camera centre
  localparam int SQ_W  = 37;  // squared distances
  localparam int XY_W  = 47;  // CORDIC vector components
  localparam int Z_W   = 31;  // CORDIC angle accumulator
  localparam int TAN_W = 26;  // arctangent table entries
  localparam int TICK_W = 15; // signed angle after one sweep step

  localparam logic signed [Z_W-1:0] FULL_FX = Z_W'(FULL_TURN * 65536);
  localparam logic signed [Z_W-1:0] HALF_FX = Z_W'(HALF_TURN * 65536);

  // Configuration register indexes.
  localparam logic [2:0] REG_SWEEP_STEP = 3'd0;
  localparam logic [2:0] REG_SWEEP_MIN  = 3'd1;
  localparam logic [2:0] REG_SWEEP_MAX  = 3'd2;
  localparam logic [2:0] REG_VIEW_RANGE = 3'd3;
  localparam logic [2:0] REG_CONE_WIDTH = 3'd4;
  localparam logic [2:0] REG_CENTER_X   = 3'd5;
  localparam logic [2:0] REG_CENTER_Y   = 3'd6;

  // Operation codes of an input item.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_TEST = 1'b1;

  // Index of the last of the five test points (the rectangle centre).
  localparam logic [2:0] LAST_POINT = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIST_X,
    ST_DIST_Y,
    ST_DIST_R,
    ST_CINIT,
    ST_CORDIC,
    ST_WRAP,
    ST_CONE,
    ST_DONE
  } ssvt_state_e;

  // atan(2^-i) in units of 1/(16*65536) degree, rounded to nearest.
  function automatic logic [TAN_W-1:0] atan_entry(input logic [4:0] idx);
    logic [TAN_W-1:0] t;
    case (idx)
      5'd0:  t = 26'd47185920;
      5'd1:  t = 26'd27855475;
      5'd2:  t = 26'd14718068;
      5'd3:  t = 26'd7471121;
      5'd4:  t = 26'd3750058;
      5'd5:  t = 26'd1876857;
      5'd6:  t = 26'd938658;
      5'd7:  t = 26'd469357;
      5'd8:  t = 26'd234682;
      5'd9:  t = 26'd117342;
      5'd10: t = 26'd58671;
      5'd11: t = 26'd29335;
      5'd12: t = 26'd14668;
      5'd13: t = 26'd7334;
      5'd14: t = 26'd3667;
      5'd15: t = 26'd1833;
      5'd16: t = 26'd917;
      5'd17: t = 26'd458;
      5'd18: t = 26'd229;
      5'd19: t = 26'd115;
      5'd20: t = 26'd57;
      5'd21: t = 26'd29;
      5'd22: t = 26'd14;
      5'd23: t = 26'd7;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/ssvt_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssvt_in_if: input channel of the sweeping sector visibility test
// Carries one tick or rectangle test item per transfer.
// ----------------------------------------------------------------------------
interface ssvt_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [15:0] rect_x;
  logic signed [15:0] rect_y;
  logic        [11:0] rect_w;
  logic        [11:0] rect_h;

  modport source (
    output valid, operation, rect_x, rect_y, rect_w, rect_h,
    input  ready
  );

  modport sink (
    input  valid, operation, rect_x, rect_y, rect_w, rect_h,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/core/ssvt_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssvt_out_if: result channel of the sweeping sector visibility test
// Carries the visibility flag and the view angle, one result per transfer.
// ----------------------------------------------------------------------------
interface ssvt_out_if;
  logic        valid;
  logic        ready;
  logic        seen;
  logic [12:0] view_angle;

  modport source (
    output valid, seen, view_angle,
    input  ready
  );

  modport sink (
    input  valid, seen, view_angle,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/core/sweeping_sector_visibility_test_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sweeping_sector_visibility_test_top: sweeping view cone visibility test
// Usage:
//   Items arrive on in_i and every item gives exactly one result on out_o.
//   A tick item steps the view angle toward the current bound and, once it
//   reaches or passes it, clamps it there and reverses the sweep; its
//   result reports seen as 0. A test item checks the four corners and the
//   centre of a rectangle against the view sector and stops at the first
//   point that is seen. One sequencer and one shared squarer and CORDIC
//   adder stage do all the work, so in_i.ready is high only while the
//   sequencer is idle. A test point runs the setup and distance states;
//   one in range also runs CINIT, the CORDIC iteration loop (which
//   dominates), WRAP and CONE. A tick goes straight to the result state.
//   The result waits in an output register; the next item is taken while
//   it waits, and a second result is held back until out_o.ready frees it.
//   Registers are written on cfg_we_i; the user must write them only while
//   the block is idle, as the block itself does not enforce it. Reset
//   clears the sweep angle to 0, sets an upward sweep and loads the
//   register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sweeping_sector_visibility_test_top
  import ssvt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  ssvt_in_if.sink          in_i,
  ssvt_out_if.source       out_o
);

  // Configuration registers.
  logic        [7:0]       sweep_step_q;
  logic        [ANG_W-1:0] sweep_min_q;
  logic        [ANG_W-1:0] sweep_max_q;
  logic        [11:0]      view_range_q;
  logic        [ANG_W-1:0] cone_width_q;
  logic signed [15:0]      center_x_q;
  logic signed [15:0]      center_y_q;

  // Sweep state.
  logic [ANG_W-1:0] sweep_angle_q, sweep_angle_d;
  logic             sweep_up_q, sweep_up_d;

  // Sequencer and datapath registers.
  ssvt_state_e             state_q, state_d;
  logic        [2:0]       pt_q, pt_d;
  logic        [ITER_W-1:0] iter_q, iter_d;
  logic                    seen_q, seen_d;
  logic signed [15:0]      rect_x_q, rect_y_q;
  logic        [11:0]      rect_w_q, rect_h_q;
  logic signed [D_W-1:0]   dx_q, dx_d, dy_q, dy_d;
  logic        [SQ_W-1:0]  sq_q, sq_d;
  logic signed [XY_W-1:0]  x_q, x_d, y_q, y_d;
  logic signed [Z_W-1:0]   z_q, z_d;
  logic signed [Z_W-1:0]   diff_q, diff_d;
  logic                    out_valid_q, out_valid_d;
  logic                    out_seen_q;
  logic        [ANG_W-1:0] out_angle_q;

  // Handshake events.
  logic in_fire, tick_fire, out_load;

  // Combinational helpers.
  logic signed [D_W-1:0]     mul_a;
  logic signed [2*D_W-1:0]   mul_p;
  logic                      in_range;
  logic                      zero_vec;
  logic                      cone_hit;
  logic                      last_pt;
  logic signed [TICK_W-1:0]  tick_a;
  logic        [ANG_W-1:0]   cam_mod;
  logic signed [Z_W-1:0]     cam_fx;
  logic signed [Z_W-1:0]     z_wrap;
  logic signed [Z_W-1:0]     diff_wrap;
  logic        [Z_W-1:0]     diff_abs;
  logic        [12:0]        off_x, off_y;
  logic signed [D_W-1:0]     cx_neg, cy_neg;
  logic signed [XY_W-1:0]    x_sh, y_sh;
  logic signed [D_W-1:0]     vx, vy;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign tick_fire  = in_fire && (in_i.operation == OP_TICK);
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  assign out_o.valid      = out_valid_q;
  assign out_o.seen       = out_seen_q;
  assign out_o.view_angle = out_angle_q;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_step_q <= 8'd4;
      sweep_min_q  <= ANG_W'(0);
      sweep_max_q  <= ANG_W'(FULL_TURN);
      view_range_q <= 12'd200;
      cone_width_q <= ANG_W'(960);
      center_x_q   <= 16'sd16;
      center_y_q   <= 16'sd16;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SWEEP_STEP: sweep_step_q <= cfg_data_i[7:0];
        REG_SWEEP_MIN:  sweep_min_q  <= cfg_data_i[ANG_W-1:0];
        REG_SWEEP_MAX:  sweep_max_q  <= cfg_data_i[ANG_W-1:0];
        REG_VIEW_RANGE: view_range_q <= cfg_data_i[11:0];
        REG_CONE_WIDTH: cone_width_q <= cfg_data_i[ANG_W-1:0];
        REG_CENTER_X:   center_x_q   <= signed'(cfg_data_i);
        REG_CENTER_Y:   center_y_q   <= signed'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Sweep step: the upper bound is checked before the lower one.
  always_comb begin
    sweep_angle_d = sweep_angle_q;
    sweep_up_d    = sweep_up_q;
    if (sweep_up_q) begin
      tick_a = signed'(TICK_W'(sweep_angle_q)) + signed'(TICK_W'(sweep_step_q));
    end else begin
      tick_a = signed'(TICK_W'(sweep_angle_q)) - signed'(TICK_W'(sweep_step_q));
    end
    if (tick_fire) begin
      if (tick_a >= signed'(TICK_W'(sweep_max_q))) begin
        sweep_angle_d = sweep_max_q;
        sweep_up_d    = 1'b0;
      end else if (tick_a <= signed'(TICK_W'(sweep_min_q))) begin
        sweep_angle_d = sweep_min_q;
        sweep_up_d    = 1'b1;
      end else begin
        sweep_angle_d = tick_a[ANG_W-1:0];
      end
    end
  end

  // Shared squarer: offsets during the distance test, then the range.
  always_comb begin
    case (state_q)
      ST_DIST_X: mul_a = dx_q;
      ST_DIST_Y: mul_a = dy_q;
      default:   mul_a = signed'(D_W'({view_range_q, 1'b0}));
    endcase
    mul_p    = mul_a * mul_a;
    in_range = (sq_q <= mul_p[SQ_W-1:0]);
  end

  // Test point offsets in doubled coordinates: corners, then the centre.
  always_comb begin
    case (pt_q)
      3'd1:    begin off_x = {rect_w_q, 1'b0}; off_y = '0;               end
      3'd2:    begin off_x = '0;               off_y = {rect_h_q, 1'b0}; end
      3'd3:    begin off_x = {rect_w_q, 1'b0}; off_y = {rect_h_q, 1'b0}; end
      3'd4:    begin off_x = {1'b0, rect_w_q}; off_y = {1'b0, rect_h_q}; end
      default: begin off_x = '0;               off_y = '0;               end
    endcase
    cx_neg = -(D_W'(center_x_q) <<< 1);
    cy_neg = -(D_W'(center_y_q) <<< 1);
  end

  // Bearing and cone compare helpers.
  always_comb begin
    zero_vec = (dx_q == '0) && (dy_q == '0);
    vx       = (dx_q < 0) ? -dx_q : dx_q;
    vy       = (dx_q < 0) ? -dy_q : dy_q;
    x_sh     = x_q >>> iter_q;
    y_sh     = y_q >>> iter_q;
    cam_mod  = (sweep_angle_q >= ANG_W'(FULL_TURN)) ?
               (sweep_angle_q - ANG_W'(FULL_TURN)) : sweep_angle_q;
    cam_fx   = signed'(Z_W'({cam_mod, 16'b0}));
    if (z_q < 0) begin
      z_wrap = z_q + FULL_FX;
    end else if (z_q >= FULL_FX) begin
      z_wrap = z_q - FULL_FX;
    end else begin
      z_wrap = z_q;
    end
    if (diff_q < -HALF_FX) begin
      diff_wrap = diff_q + FULL_FX;
    end else if (diff_q > HALF_FX) begin
      diff_wrap = diff_q - FULL_FX;
    end else begin
      diff_wrap = diff_q;
    end
    diff_abs = (diff_wrap < 0) ? unsigned'(-diff_wrap) : unsigned'(diff_wrap);
    cone_hit = ({diff_abs[Z_W-2:0], 1'b0} <= Z_W'({cone_width_q, 16'b0}));
    last_pt  = (pt_q == LAST_POINT);
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (in_i.operation == OP_TICK) ? ST_DONE : ST_SETUP;
        end
      end
      ST_SETUP:  state_d = ST_DIST_X;
      ST_DIST_X: state_d = ST_DIST_Y;
      ST_DIST_Y: state_d = ST_DIST_R;
      ST_DIST_R: begin
        if (in_range) begin
          state_d = ST_CINIT;
        end else begin
          state_d = last_pt ? ST_DONE : ST_SETUP;
        end
      end
      ST_CINIT: state_d = zero_vec ? ST_WRAP : ST_CORDIC;
      ST_CORDIC: begin
        if (iter_q == ITER_W'(CORDIC_ITERS - 1)) begin
          state_d = ST_WRAP;
        end
      end
      ST_WRAP: state_d = ST_CONE;
      ST_CONE: state_d = (cone_hit || last_pt) ? ST_DONE : ST_SETUP;
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath updates under the sequencer.
  always_comb begin
    pt_d        = pt_q;
    iter_d      = iter_q;
    seen_d      = seen_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    sq_d        = sq_q;
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    diff_d      = diff_q;
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          pt_d   = '0;
          seen_d = 1'b0;
        end
      end
      ST_SETUP: begin
        dx_d = (D_W'(rect_x_q) <<< 1) + D_W'(off_x) + cx_neg;
        dy_d = (D_W'(rect_y_q) <<< 1) + D_W'(off_y) + cy_neg;
      end
      ST_DIST_X: sq_d = mul_p[SQ_W-1:0];
      ST_DIST_Y: sq_d = sq_q + mul_p[SQ_W-1:0];
      ST_DIST_R: begin
        if (!in_range) begin
          pt_d = pt_q + 3'd1;
        end
      end
      ST_CINIT: begin
        // Left half plane: rotate by half a turn so CORDIC converges.
        x_d    = XY_W'(vx) <<< PRE_SHIFT;
        y_d    = XY_W'(vy) <<< PRE_SHIFT;
        z_d    = (dx_q < 0) ? HALF_FX : '0;
        iter_d = '0;
      end
      ST_CORDIC: begin
        if (y_q > 0) begin
          x_d = x_q + y_sh;
          y_d = y_q - x_sh;
          z_d = z_q + Z_W'(atan_entry(5'(iter_q)));
        end else begin
          x_d = x_q - y_sh;
          y_d = y_q + x_sh;
          z_d = z_q - Z_W'(atan_entry(5'(iter_q)));
        end
        iter_d = iter_q + ITER_W'(1);
      end
      ST_WRAP: diff_d = z_wrap - cam_fx;
      ST_CONE: begin
        seen_d = cone_hit;
        pt_d   = pt_q + 3'd1;
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      sweep_angle_q <= '0;
      sweep_up_q    <= 1'b1;
      pt_q          <= '0;
      iter_q        <= '0;
      seen_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      sweep_angle_q <= sweep_angle_d;
      sweep_up_q    <= sweep_up_d;
      pt_q          <= pt_d;
      iter_q        <= iter_d;
      seen_q        <= seen_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rect_x_q <= in_i.rect_x;
      rect_y_q <= in_i.rect_y;
      rect_w_q <= in_i.rect_w;
      rect_h_q <= in_i.rect_h;
    end
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    sq_q   <= sq_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    diff_q <= diff_d;
    if (out_load) begin
      out_seen_q  <= seen_q;
      out_angle_q <= sweep_angle_q;
    end
  end

`ifndef SYNTH
  // The sweep angle moves only on a tick transfer.
  a_angle_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tick_fire |=> $stable(sweep_angle_q))
    else $error("sweep angle changed without a tick");

  // A tick goes straight to the result stage and reports nothing seen.
  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_fire |=> (state_q == ST_DONE) && !seen_q)
    else $error("tick did not produce an unseen result");

  // The point counter never passes the rectangle centre while testing.
  a_point_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SETUP) |-> (pt_q <= LAST_POINT))
    else $error("test point index out of range");

  // A pending result is never overwritten before it is taken.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> out_valid_q && $stable(out_angle_q))
    else $error("pending result lost");
`endif

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sweeping sector visibility test
// Sends sweep ticks and rectangle tests through the input channel, works
// out the expected flag and view angle for every accepted item with an
// independent bit-exact model, and compares each returned result in order.
// Both channels idle and stall at random while the registers step through
// default, extreme and random settings between phases.
// ----------------------------------------------------------------------------

// Angle limits in the fixed-point bearing domain.
localparam longint FULL_TURN_FX = longint'(ssvt_pkg::FULL_TURN) <<< ssvt_pkg::FRAC_SHIFT;
localparam longint HALF_TURN_FX = longint'(ssvt_pkg::HALF_TURN) <<< ssvt_pkg::FRAC_SHIFT;

typedef struct {
  logic               operation;
  logic signed [15:0] rect_x;
  logic signed [15:0] rect_y;
  logic        [11:0] rect_w;
  logic        [11:0] rect_h;
} rect_item_t;

typedef struct {
  logic        seen;
  logic [12:0] view_angle;
} view_result_t;

// Holds its own copy of the sweep state and registers, predicts the result
// of every accepted item and compares returned results in order.
class visibility_scoreboard;
  bit        [7:0]  sweep_step;
  bit        [12:0] sweep_min;
  bit        [12:0] sweep_max;
  bit        [11:0] view_range;
  bit        [12:0] cone_width;
  bit signed [15:0] center_x;
  bit signed [15:0] center_y;
  bit        [12:0] sweep_angle;
  bit               sweep_up;
  view_result_t     pending_views[$];
  int unsigned      mismatches;

  function new();
    sweep_step  = 8'd4;
    sweep_min   = 13'd0;
    sweep_max   = 13'd5760;
    view_range  = 12'd200;
    cone_width  = 13'd960;
    center_x    = 16'sd16;
    center_y    = 16'sd16;
    sweep_angle = 13'd0;
    sweep_up    = 1'b1;
    mismatches  = 0;
  endfunction

  // Mirror of a register write; unknown indexes leave everything alone.
  function void apply_reg(logic [2:0] idx, logic [15:0] data);
    case (idx)
      ssvt_pkg::REG_SWEEP_STEP: sweep_step = data[7:0];
      ssvt_pkg::REG_SWEEP_MIN:  sweep_min  = data[12:0];
      ssvt_pkg::REG_SWEEP_MAX:  sweep_max  = data[12:0];
      ssvt_pkg::REG_VIEW_RANGE: view_range = data[11:0];
      ssvt_pkg::REG_CONE_WIDTH: cone_width = data[12:0];
      ssvt_pkg::REG_CENTER_X:   center_x   = signed'(data);
      ssvt_pkg::REG_CENTER_Y:   center_y   = signed'(data);
      default: ;
    endcase
  endfunction

  // Arctangent of 2^-i in 1/(16*65536) degree.
  function longint atan_step(int i);
    case (i)
      0:  return 47185920;
      1:  return 27855475;
      2:  return 14718068;
      3:  return 7471121;
      4:  return 3750058;
      5:  return 1876857;
      6:  return 938658;
      7:  return 469357;
      8:  return 234682;
      9:  return 117342;
      10: return 58671;
      11: return 29335;
      12: return 14668;
      13: return 7334;
      14: return 3667;
      15: return 1833;
      16: return 917;
      17: return 458;
      18: return 229;
      19: return 115;
      20: return 57;
      21: return 29;
      22: return 14;
      23: return 7;
      default: return 0;
    endcase
  endfunction

  // CORDIC vectoring bearing of a doubled offset, wrapped into one turn.
  function longint bearing(longint dx, longint dy);
    longint x, y, z, xs, ys;
    if (dx == 0 && dy == 0) return 0;
    x = dx <<< ssvt_pkg::PRE_SHIFT;
    y = dy <<< ssvt_pkg::PRE_SHIFT;
    z = 0;
    // Vectors in the left half plane start from 180 degrees.
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF_TURN_FX;
    end
    for (int i = 0; i < ssvt_pkg::CORDIC_ITERS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_step(i);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_step(i);
      end
    end
    while (z < 0) z = z + FULL_TURN_FX;
    while (z >= FULL_TURN_FX) z = z - FULL_TURN_FX;
    return z;
  endfunction

  // Range and cone test of one point given in half-pixel units.
  function bit point_in_cone(longint px2, longint py2);
    longint dx, dy, reach, cam, diff;
    dx    = px2 - 2 * longint'(center_x);
    dy    = py2 - 2 * longint'(center_y);
    reach = 2 * longint'(view_range);
    if (dx * dx + dy * dy > reach * reach) return 1'b0;
    cam  = longint'(sweep_angle % ssvt_pkg::FULL_TURN) <<< ssvt_pkg::FRAC_SHIFT;
    diff = bearing(dx, dy) - cam;
    if (diff < -HALF_TURN_FX) diff = diff + FULL_TURN_FX;
    if (diff > HALF_TURN_FX) diff = diff - FULL_TURN_FX;
    if (diff < 0) diff = -diff;
    return (2 * diff) <= (longint'(cone_width) <<< ssvt_pkg::FRAC_SHIFT);
  endfunction

  // Advances the sweep or tests the rectangle and queues the result.
  function void note_item(rect_item_t it);
    view_result_t predicted;
    int           next_angle;
    longint       x2, y2, w2, h2;
    predicted.seen = 1'b0;
    if (it.operation == ssvt_pkg::OP_TICK) begin
      next_angle = sweep_up ? int'(sweep_angle) + int'(sweep_step)
                            : int'(sweep_angle) - int'(sweep_step);
      // The upper bound wins when both bounds are crossed.
      if (next_angle >= int'(sweep_max)) begin
        sweep_angle = sweep_max;
        sweep_up    = 1'b0;
      end else if (next_angle <= int'(sweep_min)) begin
        sweep_angle = sweep_min;
        sweep_up    = 1'b1;
      end else begin
        sweep_angle = next_angle[12:0];
      end
    end else begin
      x2 = 2 * longint'(it.rect_x);
      y2 = 2 * longint'(it.rect_y);
      w2 = 2 * longint'(it.rect_w);
      h2 = 2 * longint'(it.rect_h);
      predicted.seen = point_in_cone(x2, y2) || point_in_cone(x2 + w2, y2) ||
                       point_in_cone(x2, y2 + h2) || point_in_cone(x2 + w2, y2 + h2) ||
                       point_in_cone(x2 + w2 / 2, y2 + h2 / 2);
    end
    predicted.view_angle = sweep_angle;
    pending_views.push_back(predicted);
  endfunction

  function void check_result(logic seen, logic [12:0] view_angle);
    view_result_t predicted;
    if (pending_views.size() == 0) begin
      $error("result transfer with no prediction pending: seen %0d view_angle %0d",
             seen, view_angle);
      mismatches++;
    end else begin
      predicted = pending_views.pop_front();
      if (seen !== predicted.seen) begin
        $error("seen: expected %0d, got %0d", predicted.seen, seen);
        mismatches++;
      end
      if (view_angle !== predicted.view_angle) begin
        $error("view_angle: expected %0d, got %0d", predicted.view_angle, view_angle);
        mismatches++;
      end
    end
  endfunction

  function bit drained();
    return pending_views.size() == 0;
  endfunction
endclass

module tb;
  import ssvt_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 5;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 136;
  localparam int IDLE_SETTLE  = 8;
  localparam int END_SETTLE   = 130;
  localparam int LONG_HOLD    = 400;
  localparam int QUIET_LIMIT  = 5000;

  // Index past the last register; writes to it must have no effect.
  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        cfg_we_i   = 1'b0;
  logic [2:0]  cfg_idx_i  = '0;
  logic [15:0] cfg_data_i = '0;

  ssvt_in_if  in_ch ();
  ssvt_out_if out_ch ();

  sweeping_sector_visibility_test_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  visibility_scoreboard sb;
  int hold_requests = 0;
  bit steady        = 1'b0;

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [15:0] clamp16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Most rectangles land around the camera so both outcomes are common;
  // the rest are raw random bit patterns.
  function automatic rect_item_t random_item();
    rect_item_t  it;
    int unsigned roll;
    int          span, ox, oy;
    roll         = $urandom_range(0, 99);
    it.operation = (roll < 30) ? OP_TICK : OP_TEST;
    if (roll >= 30 && roll < 44) begin
      it.rect_x = 16'($urandom);
      it.rect_y = 16'($urandom);
      it.rect_w = 12'($urandom);
      it.rect_h = 12'($urandom);
    end else begin
      span = int'(sb.view_range) + 8;
      if ($urandom_range(0, 4) == 0) begin
        it.rect_w = 12'($urandom);
        it.rect_h = 12'($urandom);
      end else begin
        it.rect_w = 12'($urandom_range(0, (span / 2 > 4095) ? 4095 : span / 2));
        it.rect_h = 12'($urandom_range(0, (span / 2 > 4095) ? 4095 : span / 2));
      end
      ox = int'($urandom_range(0, 3 * span)) - (3 * span) / 2;
      oy = int'($urandom_range(0, 3 * span)) - (3 * span) / 2;
      it.rect_x = clamp16(int'(sb.center_x) + ox - int'(it.rect_w) / 2);
      it.rect_y = clamp16(int'(sb.center_y) + oy - int'(it.rect_h) / 2);
    end
    return it;
  endfunction

  // Offers one item, after a random gap outside steady phases, and waits for its transfer.
  // Valid stays high afterwards so the next item can follow back to back.
  task automatic send_item(input rect_item_t it);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= it.operation;
    in_ch.rect_x    <= it.rect_x;
    in_ch.rect_y    <= it.rect_y;
    in_ch.rect_w    <= it.rect_w;
    in_ch.rect_h    <= it.rect_h;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_item(it);
  endtask

  task automatic send_rect(input logic op, input int x, input int y, input int w, input int h);
    rect_item_t it;
    it.operation = op;
    it.rect_x    = 16'(x);
    it.rect_y    = 16'(y);
    it.rect_w    = 12'(w);
    it.rect_h    = 12'(h);
    send_item(it);
  endtask

  // Stops offering and waits until every predicted result has returned.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (!sb.drained());
  endtask

  task automatic settle_idle();
    drain_results();
    repeat (IDLE_SETTLE) @(posedge clk_i);
  endtask

  task automatic program_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.apply_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // The first phases pin the registers at their extremes and with crossed
  // bounds; the later ones draw random settings.
  task automatic configure_phase(input int phase);
    int          step, lo, hi, reach, cone, swap;
    logic [15:0] cx, cy;
    case (phase)
      0: begin
        step = 255; lo = 0; hi = 8191; reach = 4095; cone = 8191;
        cx = 16'h7fff; cy = 16'h8000;
      end
      1: begin
        step = 0; lo = 0; hi = 0; reach = 0; cone = 0;
        cx = 16'h8000; cy = 16'h7fff;
      end
      2: begin
        step = 200; lo = 5000; hi = 1000; reach = 300; cone = 5760;
        cx = 16'h0000; cy = 16'h0000;
      end
      default: begin
        step = $urandom_range(0, 255);
        lo   = $urandom_range(0, 5760);
        hi   = $urandom_range(0, 5760);
        if (lo > hi && $urandom_range(0, 3) != 0) begin
          swap = lo;
          lo   = hi;
          hi   = swap;
        end
        if ($urandom_range(0, 4) == 0) hi = $urandom_range(5761, 8191);
        reach = $urandom_range(0, 1) ? $urandom_range(0, 600) : $urandom_range(0, 4095);
        cone  = ($urandom_range(0, 5) == 0) ? $urandom_range(5761, 8191)
                                            : $urandom_range(0, 5760);
        cx = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000) - 2000);
        cy = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000) - 2000);
      end
    endcase
    program_reg(REG_SWEEP_STEP, 16'(step));
    program_reg(REG_SWEEP_MIN, 16'(lo));
    program_reg(REG_SWEEP_MAX, 16'(hi));
    program_reg(REG_VIEW_RANGE, 16'(reach));
    program_reg(REG_CONE_WIDTH, 16'(cone));
    program_reg(REG_CENTER_X, cx);
    program_reg(REG_CENTER_Y, cy);
  endtask

  // Stimulus: directed items under the reset and programmed sweep settings, then random phases.
  initial begin
    int phase, n;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_TICK;
    in_ch.rect_x    = '0;
    in_ch.rect_y    = '0;
    in_ch.rect_w    = '0;
    in_ch.rect_h    = '0;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Point on the camera centre, the exact range boundary, one pixel past
    // it, points behind and beside the view, and the coordinate extremes.
    send_rect(OP_TEST, 16, 16, 0, 0);
    send_rect(OP_TEST, 216, 16, 0, 0);
    send_rect(OP_TEST, 217, 16, 0, 0);
    send_rect(OP_TEST, -100, 16, 0, 0);
    send_rect(OP_TEST, 16, 100, 0, 0);
    send_rect(OP_TEST, -32768, -32768, 4095, 4095);
    send_rect(OP_TEST, 32767, 32767, 4095, 4095);
    send_rect(OP_TEST, -32768, 32767, 0, 4095);
    send_rect(OP_TEST, 0, 0, 4095, 0);
    send_rect(OP_TICK, 0, 0, 0, 0);
    send_rect(OP_TICK, 0, 0, 0, 0);

    // Clamping at both bounds with the largest step; the unused index
    // must not disturb anything.
    settle_idle();
    program_reg(REG_SWEEP_STEP, 16'd255);
    program_reg(REG_SWEEP_MIN, 16'd300);
    program_reg(REG_SWEEP_MAX, 16'd600);
    program_reg(REG_UNUSED, 16'hffff);
    repeat (5) send_rect(OP_TICK, 0, 0, 0, 0);

    // Lower bound above the upper bound.
    settle_idle();
    program_reg(REG_SWEEP_MIN, 16'd700);
    repeat (3) send_rect(OP_TICK, 0, 0, 0, 0);

    // Bounds above a full turn: the bearing test uses the reduced angle.
    settle_idle();
    program_reg(REG_SWEEP_MAX, 16'd8191);
    program_reg(REG_SWEEP_MIN, 16'd8000);
    send_rect(OP_TICK, 0, 0, 0, 0);
    send_rect(OP_TEST, -50, 60, 0, 0);
    send_rect(OP_TEST, 16, 16, 0, 0);
    send_rect(OP_TICK, 0, 0, 0, 0);
    send_rect(OP_TEST, -50, 60, 0, 0);

    for (phase = 0; phase < PHASES; phase++) begin
      settle_idle();
      configure_phase(phase);
      steady = (phase % 4 == 3);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // Long result back-pressure while items keep coming.
        if (phase == 4 && n == 10) hold_requests++;
        // Let the block run completely empty once mid-phase.
        if (phase == 6 && n == 50) drain_results();
        send_item(random_item());
      end
    end

    drain_results();
    repeat (END_SETTLE) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.drained()) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Result side: checks each transfer and stalls ready at random.
  initial begin : result_sink
    int stall_left;
    int hold_served;
    int gap;
    stall_left   = 0;
    hold_served  = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.seen, out_ch.view_angle);
        if (stall_left > 0) begin
          stall_left--;
          out_ch.ready <= 1'b0;
        end else if (hold_served != hold_requests) begin
          hold_served  = hold_requests;
          stall_left   = LONG_HOLD - 1;
          out_ch.ready <= 1'b0;
        end else begin
          gap = steady ? 0 : pick_gap();
          if (gap > 0) begin
            stall_left   = gap - 1;
            out_ch.ready <= 1'b0;
          end else begin
            out_ch.ready <= 1'b1;
          end
        end
      end
    end
  end

  // Ends the run when no transfer happens on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $error("no transfer for %0d cycles", QUIET_LIMIT);
    $display("FAIL");
    $finish;
  end

endmodule
